FILE: hw/rtl/css_pkg.sv
// Shared constants, operation and error codes and control types for the cursor sequence store.
package css_pkg;

  // Default sizing of the store
  localparam int CSS_DEPTH     = 32;
  localparam int CSS_WORD_BITS = 32;

  // Port widths
  localparam int OP_W    = 4;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 6;
  localparam int ERR_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_START     = 4'd0;
  localparam logic [OP_W-1:0] OP_END       = 4'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE   = 4'd2;
  localparam logic [OP_W-1:0] OP_RETREAT   = 4'd3;
  localparam logic [OP_W-1:0] OP_INSERT    = 4'd4;
  localparam logic [OP_W-1:0] OP_ATTACH    = 4'd5;
  localparam logic [OP_W-1:0] OP_REMOVE    = 4'd6;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd7;
  localparam logic [OP_W-1:0] OP_APPEND    = 4'd8;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 4'd9;
  localparam logic [OP_W-1:0] OP_READ      = 4'd10;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_CUR = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd3;

  // Shift request from the sequencer to the store
  typedef struct packed {
    logic go;
    logic open_gap;
  } css_shift_cmd_t;

endpackage

FILE: hw/rtl/css_store.sv
// Word memory with a one-move-per-cycle shift engine and a single access port.
module css_store import css_pkg::*; #(
  parameter int DEPTH     = CSS_DEPTH,
  parameter int WORD_BITS = CSS_WORD_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  css_shift_cmd_t       cmd,
  input  logic [AW-1:0]        first,
  input  logic [AW-1:0]        moves,
  output logic                 shift_done,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        left;
  logic                 dir_open;
  logic                 pend;
  logic [AW-1:0]        pend_addr;
  logic                 moving;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  assign moving = (left != '0);

  // Advance the move engine: read one source per cycle, write it one place over next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.go) begin
        left <= moves;
      end else if (moving) begin
        left <= left - AW'(1);
      end
      pend <= moving;
    end
  end

  // Hold source pointer, direction and pending write address
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rd_ptr   <= first;
      dir_open <= cmd.open_gap;
    end else if (moving) begin
      rd_ptr <= dir_open ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
    end
    pend_addr <= dir_open ? rd_ptr + AW'(1) : rd_ptr - AW'(1);
  end

  assign shift_done = pend && !moving;

  // Select memory port owners
  assign mem_we    = pend || wr_en;
  assign mem_waddr = pend ? pend_addr : wr_addr;
  assign mem_wdata = pend ? rd_data : wr_data;
  assign mem_re    = moving || rd_en;
  assign mem_raddr = moving ? rd_ptr : rd_addr;

  // Memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

FILE: hw/rtl/cursor_sequence_store_top.sv
// Cursor sequence store: an ordered word store with a cursor, run by a small sequencer.
// Sequence: an accepted transfer steps through S_SHIFT (only when an insert or remove
//   moves entries, one per cycle), S_WRITE, S_RDIDX, S_RDCUR and S_DONE, where done pulses.
// Busy stays high until done has shown, so a new transfer is taken only after the last ends.
// Reset (rst, synchronous): count and cursor clear to zero; store contents stay undefined.
// The receiver cannot stall: each result stands on the ports for the single done cycle.
module cursor_sequence_store_top import css_pkg::*; #(
  parameter int DEPTH     = CSS_DEPTH,
  parameter int WORD_BITS = CSS_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [VALUE_W-1:0] value,
  input  logic [INDEX_W-1:0] index,
  output logic               done,
  output logic [VALUE_W-1:0] current_value,
  output logic               has_current,
  output logic [COUNT_W-1:0] count,
  output logic [COUNT_W-1:0] cursor_pos,
  output logic [VALUE_W-1:0] read_value,
  output logic [ERR_W-1:0]   error_code
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_WRITE = 6'b000100,
    S_RDIDX = 6'b001000,
    S_RDCUR = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cursor;
  logic [ERR_W-1:0]     err;
  logic [WORD_BITS-1:0] val;
  logic                 do_write;
  logic [AW-1:0]        wpos;
  logic                 rd_idx;
  logic [AW-1:0]        idx_addr;
  logic [WORD_BITS-1:0] read_word;

  logic                 accept;
  logic                 cur_ok;
  logic                 full;
  logic                 idx_ok;
  logic [CW-1:0]        pos;
  logic [ERR_W-1:0]     err_next;
  logic [CW-1:0]        cnt_next;
  logic [CW-1:0]        cursor_next;
  logic                 shift_open;
  logic [AW-1:0]        shift_first;
  logic [AW-1:0]        shift_moves;
  logic                 write_next;
  logic [AW-1:0]        wpos_next;
  logic                 rd_idx_next;

  css_shift_cmd_t       shift_cmd;
  logic                 shift_done;
  logic                 mem_wr_en;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign cur_ok = (cursor < cnt);
  assign full   = (cnt >= CW'(DEPTH));
  assign idx_ok = (CMPW'(index) < CMPW'(cnt));

  // Decode the operation against the current count and cursor
  always_comb begin
    err_next    = ERR_OK;
    cnt_next    = cnt;
    cursor_next = cursor;
    pos         = '0;
    shift_open  = 1'b0;
    shift_first = '0;
    shift_moves = '0;
    write_next  = 1'b0;
    wpos_next   = '0;
    rd_idx_next = 1'b0;
    case (op)
      OP_START: begin
        cursor_next = '0;
      end
      OP_END: begin
        cursor_next = (cnt != '0) ? cnt - CW'(1) : '0;
      end
      OP_ADVANCE: begin
        if (cur_ok) cursor_next = cursor + CW'(1);
        else        err_next    = ERR_NO_CUR;
      end
      OP_RETREAT: begin
        if (cursor != '0) cursor_next = cursor - CW'(1);
      end
      OP_INSERT, OP_ATTACH, OP_INS_FRONT, OP_APPEND: begin
        if (full) begin
          err_next = ERR_FULL;
        end else begin
          if (op == OP_INSERT)      pos = cur_ok ? cursor : '0;
          else if (op == OP_ATTACH) pos = cur_ok ? cursor + CW'(1) : cnt;
          else if (op == OP_APPEND) pos = cnt;
          else                      pos = '0;
          if (op != OP_APPEND) cursor_next = pos;
          shift_open  = 1'b1;
          shift_first = AW'(cnt - CW'(1));
          shift_moves = AW'(cnt - pos);
          write_next  = 1'b1;
          wpos_next   = AW'(pos);
          cnt_next    = cnt + CW'(1);
        end
      end
      OP_REMOVE, OP_REM_FRONT: begin
        if (!cur_ok) begin
          err_next = ERR_NO_CUR;
        end else begin
          pos         = (op == OP_REMOVE) ? cursor : '0;
          shift_first = AW'(pos + CW'(1));
          shift_moves = AW'(cnt - CW'(1) - pos);
          cnt_next    = cnt - CW'(1);
        end
      end
      OP_READ: begin
        if (idx_ok) rd_idx_next = 1'b1;
        else        err_next    = ERR_RANGE;
      end
      default: begin
      end
    endcase
  end

  assign shift_cmd.go       = accept && (shift_moves != '0);
  assign shift_cmd.open_gap = shift_open;

  // Step the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = shift_cmd.go ? S_SHIFT : S_WRITE;
      S_SHIFT: if (shift_done) state_next = S_WRITE;
      S_WRITE: state_next = S_RDIDX;
      S_RDIDX: state_next = S_RDCUR;
      S_RDCUR: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt    <= cnt_next;
        cursor <= cursor_next;
      end
    end
  end

  // Hold the decoded transfer for the later steps
  always_ff @(posedge clk) begin
    if (accept) begin
      err      <= err_next;
      val      <= WORD_BITS'(value);
      do_write <= write_next;
      wpos     <= wpos_next;
      rd_idx   <= rd_idx_next;
      idx_addr <= AW'(index);
    end
    if (state == S_RDCUR) begin
      read_word <= rd_idx ? mem_rd_data : '0;
    end
  end

  // Drive single accesses: new word, indexed read, then word under the cursor
  assign mem_wr_en   = (state == S_WRITE) && do_write;
  assign mem_rd_en   = ((state == S_RDIDX) && rd_idx) || ((state == S_RDCUR) && cur_ok);
  assign mem_rd_addr = (state == S_RDIDX) ? idx_addr : AW'(cursor);

  css_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (shift_cmd),
    .first      (shift_first),
    .moves      (shift_moves),
    .shift_done (shift_done),
    .wr_en      (mem_wr_en),
    .wr_addr    (wpos),
    .wr_data    (val),
    .rd_en      (mem_rd_en),
    .rd_addr    (mem_rd_addr),
    .rd_data    (mem_rd_data)
  );

  // Present the result for the done cycle
  assign done          = (state == S_DONE);
  assign has_current   = cur_ok;
  assign current_value = cur_ok ? VALUE_W'(mem_rd_data) : '0;
  assign count         = COUNT_W'(cnt);
  assign cursor_pos    = COUNT_W'(cursor);
  assign read_value    = VALUE_W'(read_word);
  assign error_code    = err;

`ifndef ASSERT_OFF
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= cnt)
    else $error("cursor beyond stored count");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after a transfer");

  a_shift_in_state: assert property (@(posedge clk) disable iff (rst)
    shift_done |-> (state == S_SHIFT))
    else $error("shift finished outside the shift step");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(cnt) && $stable(cursor))
    else $error("count or cursor moved while busy");
`endif

endmodule
